// ===== rtl/core/wodo_pkg.sv =====
// ----------------------------------------------------------------------------
// wodo_pkg
// Shared types and constants for the wheel encoder speed and odometer block.
// ----------------------------------------------------------------------------
package wodo_pkg;

    // Window depth default
    localparam int WINDOW_SIZE_DEF = 10;

    // Request codes
    localparam logic [1:0] OP_CAPTURE   = 2'd0;
    localparam logic [1:0] OP_POLL      = 2'd1;
    localparam logic [1:0] OP_ZERO_DIST = 2'd2;
    localparam logic [1:0] OP_ZERO_TIME = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_REC_EN    = 2'd0;
    localparam logic [1:0] CFG_MIN_TICKS = 2'd1;
    localparam logic [1:0] CFG_MIN_EDGES = 2'd2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [15:0] MIN_TICKS_RST = 16'd100;
    localparam logic [7:0]  MIN_EDGES_RST = 8'd4;

    // Divider geometry and the dividend width of each division
    localparam int DIV_W   = 32;
    localparam int DIV_CW  = 6;
    localparam int PER_W   = 32;
    localparam int VEL_W   = 19;
    localparam int AVG_W   = 16;

    // 625 timer ticks give 4 hundredths of a second. The step count is the tick
    // sum times 2^26 / 625 rounded up, exact for tick sums below 2^17.
    localparam logic [9:0]  TICKS_PER_STEP = 10'd625;
    localparam logic [16:0] TIME_RECIP     = 17'd107375;
    localparam int          TIME_SHIFT     = 26;

    // Distance per edge is 19.5721 mm, held as 2^24 * 19.5721 rounded up;
    // the floor of count times this is exact for counts up to 255
    localparam logic [28:0] DIST_RECIP = 29'd328365350;
    localparam int          DIST_SHIFT = 24;

    // floor(4893025 / 16): velocity numerator over the average period
    localparam logic [18:0] VEL_NUM = 19'd305814;
    localparam logic [11:0] VEL_MAX = 12'hFFF;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_TIME   = 10'b00_0000_0010,
        ST_CHECK  = 10'b00_0000_0100,
        ST_PERIOD = 10'b00_0000_1000,
        ST_TSTEP  = 10'b00_0001_0000,
        ST_VEL    = 10'b00_0010_0000,
        ST_WSET   = 10'b00_0100_0000,
        ST_WUPD   = 10'b00_1000_0000,
        ST_AVG    = 10'b01_0000_0000,
        ST_OUT    = 10'b10_0000_0000
    } st_t;

endpackage

// ===== rtl/core/wheel_encoder_speed_odometer.sv =====
// ----------------------------------------------------------------------------
// wheel_encoder_speed_odometer
// Edge period accumulation, poll-driven velocity, distance, elapsed time and
// a moving average of velocity samples held in a small synchronous memory.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake           | payload
//  s_*       | in        | s_valid / s_ready   | s_op, s_timestamp
//  m_*       | out       | m_valid / m_ready   | velocity, average, distance, time, flag
//  cfg_*     | in        | cfg_we              | cfg_addr, cfg_wdata
//
//  Capture and clear requests go from idle straight to the output state. A poll
//  runs its period, velocity and average divisions back to back on the shared
//  one-bit-per-cycle divider; time and distance use constant multiplies.
//  Reset clears all control and totals; the window memory needs no clearing.
//  A result waits in the output register; the next request is taken meanwhile,
//  and only its own result stalls until the output register frees up.
// ----------------------------------------------------------------------------
module wheel_encoder_speed_odometer #(
    parameter int WINDOW_SIZE = wodo_pkg::WINDOW_SIZE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [wodo_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [wodo_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_op,
    input  logic [15:0]                       s_timestamp,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [11:0]                       m_current_velocity,
    output logic [11:0]                       m_average_velocity,
    output logic [15:0]                       m_distance_mm,
    output logic [15:0]                       m_time_hundredths,
    output logic                              m_velocity_updated
);

    localparam int POS_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
    localparam int DW     = wodo_pkg::DIV_W;
    localparam int CW     = wodo_pkg::DIV_CW;

    // Control and state
    wodo_pkg::st_t state_reg, state_next;

    logic                rec_en_reg,     rec_en_next;
    logic [15:0]         min_ticks_reg,  min_ticks_next;
    logic [7:0]          min_edges_reg,  min_edges_next;

    logic [15:0]         last_edge_reg,  last_edge_next;
    logic [31:0]         acc_reg,        acc_next;
    logic [7:0]          count_reg,      count_next;
    logic [15:0]         prev_poll_reg,  prev_poll_next;
    logic [9:0]          tick_rem_reg,   tick_rem_next;
    logic [15:0]         hund_reg,       hund_next;
    logic [15:0]         dist_reg,       dist_next;
    logic [11:0]         last_vel_reg,   last_vel_next;
    logic [POS_W-1:0]    pos_reg,        pos_next;
    logic [FILL_W-1:0]   fill_reg,       fill_next;
    logic [15:0]         wsum_reg,       wsum_next;
    logic                zs_reg,         zs_next;
    logic [11:0]         avg_reg,        avg_next;
    logic [11:0]         vel_reg,        vel_next;
    logic                upd_reg,        upd_next;
    logic [16:0]         tsum_reg,       tsum_next;
    logic [7:0]          tq_reg,         tq_next;

    // Output register
    logic                m_valid_reg,    m_valid_next;
    logic [11:0]         o_vel_reg,      o_vel_next;
    logic [11:0]         o_avg_reg,      o_avg_next;
    logic [15:0]         o_dist_reg,     o_dist_next;
    logic [15:0]         o_hund_reg,     o_hund_next;
    logic                o_upd_reg,      o_upd_next;

    // Divider
    logic [DW-1:0]       div_dvd_reg,    div_dvd_next;
    logic [DW-1:0]       div_dsr_reg,    div_dsr_next;
    logic [DW-1:0]       div_rem_reg,    div_rem_next;
    logic [DW-1:0]       div_quo_reg,    div_quo_next;
    logic [CW-1:0]       div_cnt_reg,    div_cnt_next;
    logic                div_start;
    logic [DW-1:0]       div_dvd_in;
    logic [DW-1:0]       div_dsr_in;
    logic [CW-1:0]       div_len_in;
    logic [DW:0]         div_rem_sh;
    logic [DW+1:0]       div_diff;
    logic                div_ge;
    logic                div_done;

    // Window memory
    logic [11:0]         win_mem [WINDOW_SIZE];
    logic [11:0]         win_rd_reg;
    logic                mem_we;
    logic                mem_re;

    // Datapath helpers
    logic [15:0]         cap_delta;
    logic [15:0]         poll_elapsed;
    logic [16:0]         tick_sum;
    logic [33:0]         time_prod;
    logic [16:0]         time_rest;
    logic [36:0]         dist_prod;
    logic [12:0]         dist_step;
    logic [16:0]         dist_sum;
    logic                win_full;
    logic [11:0]         win_old;
    logic [15:0]         wsum_new;
    logic [FILL_W-1:0]   fill_new;

    assign cap_delta    = s_timestamp - last_edge_reg;
    assign poll_elapsed = s_timestamp - prev_poll_reg;
    assign tick_sum     = 17'(tick_rem_reg) + 17'(poll_elapsed);
    assign time_prod    = 34'(tsum_reg) * 34'(wodo_pkg::TIME_RECIP);
    assign time_rest    = tsum_reg - 17'(tq_reg) * 17'(wodo_pkg::TICKS_PER_STEP);
    assign dist_prod    = 37'(count_reg) * 37'(wodo_pkg::DIST_RECIP);
    // Per-poll distance step stays below 8192
    assign dist_step    = dist_prod[wodo_pkg::DIST_SHIFT +: 13];
    assign dist_sum     = 17'(dist_reg) + 17'(dist_step);
    assign win_full     = (fill_reg == FILL_W'(WINDOW_SIZE));
    assign win_old      = win_full ? win_rd_reg : 12'd0;
    assign wsum_new     = wsum_reg - 16'(win_old) + 16'(vel_reg);
    assign fill_new     = win_full ? fill_reg : fill_reg + FILL_W'(1);

    assign div_done     = (div_cnt_reg == '0);

    assign s_ready            = (state_reg == wodo_pkg::ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_current_velocity = o_vel_reg;
    assign m_average_velocity = o_avg_reg;
    assign m_distance_mm      = o_dist_reg;
    assign m_time_hundredths  = o_hund_reg;
    assign m_velocity_updated = o_upd_reg;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        rec_en_next    = rec_en_reg;
        min_ticks_next = min_ticks_reg;
        min_edges_next = min_edges_reg;
        last_edge_next = last_edge_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        prev_poll_next = prev_poll_reg;
        tick_rem_next  = tick_rem_reg;
        hund_next      = hund_reg;
        dist_next      = dist_reg;
        last_vel_next  = last_vel_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        wsum_next      = wsum_reg;
        zs_next        = zs_reg;
        avg_next       = avg_reg;
        vel_next       = vel_reg;
        upd_next       = upd_reg;
        tsum_next      = tsum_reg;
        tq_next        = tq_reg;
        m_valid_next   = m_valid_reg;
        o_vel_next     = o_vel_reg;
        o_avg_next     = o_avg_reg;
        o_dist_next    = o_dist_reg;
        o_hund_next    = o_hund_reg;
        o_upd_next     = o_upd_reg;
        div_start      = 1'b0;
        div_dvd_in     = '0;
        div_dsr_in     = '0;
        div_len_in     = '0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (cfg_we) begin
            case (cfg_addr)
                wodo_pkg::CFG_REC_EN:    rec_en_next    = cfg_wdata[0];
                wodo_pkg::CFG_MIN_TICKS: min_ticks_next = cfg_wdata[15:0];
                wodo_pkg::CFG_MIN_EDGES: min_edges_next = cfg_wdata[7:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            wodo_pkg::ST_IDLE: begin
                if (s_valid) begin
                    upd_next   = 1'b0;
                    state_next = wodo_pkg::ST_OUT;
                    case (s_op)
                        wodo_pkg::OP_CAPTURE: begin
                            // drop edges with a zero delta
                            if (cap_delta != 16'd0) begin
                                last_edge_next = s_timestamp;
                                acc_next       = acc_reg + 32'(cap_delta);
                                count_next     = count_reg + 8'd1;
                            end
                        end
                        wodo_pkg::OP_POLL: begin
                            if (rec_en_reg) begin
                                prev_poll_next = s_timestamp;
                                tsum_next      = tick_sum;
                                state_next     = wodo_pkg::ST_TIME;
                            end else begin
                                state_next     = wodo_pkg::ST_CHECK;
                            end
                        end
                        wodo_pkg::OP_ZERO_DIST: begin
                            dist_next = 16'd0;
                        end
                        default: begin
                            hund_next      = 16'd0;
                            prev_poll_next = 16'd0;
                        end
                    endcase
                end
            end

            wodo_pkg::ST_TIME: begin
                tq_next    = time_prod[wodo_pkg::TIME_SHIFT +: 8];
                state_next = wodo_pkg::ST_TSTEP;
            end

            wodo_pkg::ST_TSTEP: begin
                tick_rem_next = time_rest[9:0];
                // 4 hundredths per whole step of ticks
                hund_next     = hund_reg + 16'({tq_reg, 2'b00});
                state_next    = wodo_pkg::ST_CHECK;
            end

            wodo_pkg::ST_CHECK: begin
                if (count_reg >= min_edges_reg) begin
                    upd_next = 1'b1;
                    if (count_reg != 8'd0) begin
                        div_start  = 1'b1;
                        div_dvd_in = acc_reg;
                        div_dsr_in = 32'(count_reg);
                        div_len_in = CW'(wodo_pkg::PER_W);
                        state_next = wodo_pkg::ST_PERIOD;
                    end else begin
                        vel_next   = 12'd0;
                        state_next = wodo_pkg::ST_WSET;
                    end
                end else begin
                    state_next = wodo_pkg::ST_OUT;
                end
            end

            wodo_pkg::ST_PERIOD: begin
                if (div_done) begin
                    acc_next   = 32'd0;
                    dist_next  = dist_sum[16] ? 16'hFFFF : dist_sum[15:0];
                    count_next = 8'd0;
                    if (div_quo_reg == 32'd0 || div_quo_reg < 32'(min_ticks_reg)) begin
                        vel_next   = 12'd0;
                        state_next = wodo_pkg::ST_WSET;
                    end else begin
                        div_start  = 1'b1;
                        div_dvd_in = {wodo_pkg::VEL_NUM, {(DW - wodo_pkg::VEL_W){1'b0}}};
                        div_dsr_in = div_quo_reg;
                        div_len_in = CW'(wodo_pkg::VEL_W);
                        state_next = wodo_pkg::ST_VEL;
                    end
                end
            end

            wodo_pkg::ST_VEL: begin
                if (div_done) begin
                    vel_next   = (div_quo_reg > 32'(wodo_pkg::VEL_MAX)) ?
                                 wodo_pkg::VEL_MAX : div_quo_reg[11:0];
                    state_next = wodo_pkg::ST_WSET;
                end
            end

            wodo_pkg::ST_WSET: begin
                last_vel_next = vel_reg;
                // hold back a zero sample unless the one before it was held back
                if (vel_reg == 12'd0 && !zs_reg) begin
                    zs_next    = 1'b1;
                    state_next = wodo_pkg::ST_OUT;
                end else begin
                    zs_next    = 1'b0;
                    mem_re     = 1'b1;
                    state_next = wodo_pkg::ST_WUPD;
                end
            end

            wodo_pkg::ST_WUPD: begin
                mem_we     = 1'b1;
                wsum_next  = wsum_new;
                fill_next  = fill_new;
                pos_next   = (pos_reg == POS_W'(WINDOW_SIZE - 1)) ? '0 : pos_reg + POS_W'(1);
                div_start  = 1'b1;
                div_dvd_in = {wsum_new, {(DW - wodo_pkg::AVG_W){1'b0}}};
                div_dsr_in = 32'(fill_new);
                div_len_in = CW'(wodo_pkg::AVG_W);
                state_next = wodo_pkg::ST_AVG;
            end

            wodo_pkg::ST_AVG: begin
                if (div_done) begin
                    avg_next   = div_quo_reg[11:0];
                    state_next = wodo_pkg::ST_OUT;
                end
            end

            wodo_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_vel_next   = last_vel_reg;
                    o_avg_next   = avg_reg;
                    o_dist_next  = dist_reg;
                    o_hund_next  = hund_reg;
                    o_upd_next   = upd_reg;
                    state_next   = wodo_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = wodo_pkg::ST_IDLE;
            end
        endcase
    end

    // Restoring divider, one quotient bit per cycle, MSB-aligned dividend
    assign div_rem_sh = {div_rem_reg, div_dvd_reg[DW-1]};
    assign div_diff   = {1'b0, div_rem_sh} - {2'b00, div_dsr_reg};
    assign div_ge     = !div_diff[DW+1];

    always_comb begin
        div_dvd_next = div_dvd_reg;
        div_dsr_next = div_dsr_reg;
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_cnt_next = div_cnt_reg;
        if (div_start) begin
            div_dvd_next = div_dvd_in;
            div_dsr_next = div_dsr_in;
            div_rem_next = '0;
            div_quo_next = '0;
            div_cnt_next = div_len_in;
        end else if (!div_done) begin
            div_dvd_next = {div_dvd_reg[DW-2:0], 1'b0};
            div_rem_next = div_ge ? div_diff[DW-1:0] : div_rem_sh[DW-1:0];
            div_quo_next = {div_quo_reg[DW-2:0], div_ge};
            div_cnt_next = div_cnt_reg - CW'(1);
        end
    end

    // Window memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            win_mem[pos_reg] <= vel_reg;
        end
        if (mem_re) begin
            win_rd_reg <= win_mem[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wodo_pkg::ST_IDLE;
            rec_en_reg    <= 1'b0;
            min_ticks_reg <= wodo_pkg::MIN_TICKS_RST;
            min_edges_reg <= wodo_pkg::MIN_EDGES_RST;
            last_edge_reg <= '0;
            acc_reg       <= '0;
            count_reg     <= '0;
            prev_poll_reg <= '0;
            tick_rem_reg  <= '0;
            hund_reg      <= '0;
            dist_reg      <= '0;
            last_vel_reg  <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            wsum_reg      <= '0;
            zs_reg        <= 1'b0;
            avg_reg       <= '0;
            m_valid_reg   <= 1'b0;
            div_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            rec_en_reg    <= rec_en_next;
            min_ticks_reg <= min_ticks_next;
            min_edges_reg <= min_edges_next;
            last_edge_reg <= last_edge_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            prev_poll_reg <= prev_poll_next;
            tick_rem_reg  <= tick_rem_next;
            hund_reg      <= hund_next;
            dist_reg      <= dist_next;
            last_vel_reg  <= last_vel_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            wsum_reg      <= wsum_next;
            zs_reg        <= zs_next;
            avg_reg       <= avg_next;
            m_valid_reg   <= m_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        vel_reg     <= vel_next;
        upd_reg     <= upd_next;
        tsum_reg    <= tsum_next;
        tq_reg      <= tq_next;
        o_vel_reg   <= o_vel_next;
        o_avg_reg   <= o_avg_next;
        o_dist_reg  <= o_dist_next;
        o_hund_reg  <= o_hund_next;
        o_upd_reg   <= o_upd_next;
        div_dvd_reg <= div_dvd_next;
        div_dsr_reg <= div_dsr_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
    end

endmodule

// ===== test/wodo_reading_checker.sv =====
// ----------------------------------------------------------------------------
// wodo_reading_checker
// Watches the request, result and register ports of the wheel encoder block.
// Keeps its own copy of the odometer state, predicts the reading that each
// accepted request produces, and compares every result field by field.
// ----------------------------------------------------------------------------
module wodo_reading_checker #(
    parameter int WINDOW_SIZE = wodo_pkg::WINDOW_SIZE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_we,
    input  logic [wodo_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wodo_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [1:0]                      s_op,
    input  logic [15:0]                     s_timestamp,

    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [11:0]                     m_current_velocity,
    input  logic [11:0]                     m_average_velocity,
    input  logic [15:0]                     m_distance_mm,
    input  logic [15:0]                     m_time_hundredths,
    input  logic                            m_velocity_updated,

    output int                              mismatch_count,
    output int                              readings_pending,
    output int                              readings_checked,
    output int                              velocity_samples
);
    import wodo_pkg::*;

    localparam int     TICKS_PER_STEP     = 625;
    localparam int     HUNDREDTHS_PER_STEP = 4;
    localparam longint MM_PER_EDGE_X10K   = 195721;
    localparam longint MM_SCALE           = 10000;
    localparam longint SPEED_NUM_X16      = 4893025;
    localparam longint SPEED_MAX          = 4095;
    localparam int     PRINT_LIMIT        = 40;

    typedef struct packed {
        logic [11:0] velocity;
        logic [11:0] average;
        logic [15:0] distance;
        logic [15:0] hundredths;
        logic        updated;
    } reading_t;

    // register copies
    logic        rec_enable;
    logic [15:0] min_ticks;
    logic [7:0]  min_edges;

    // odometer state
    logic [15:0] last_edge;
    logic [31:0] period_sum;
    logic [7:0]  edge_total;
    logic [15:0] last_poll;
    int          tick_carry;
    logic [15:0] hundredths;
    logic [15:0] distance;
    logic [11:0] velocity;
    logic [11:0] window_mem [WINDOW_SIZE];
    int          window_pos;
    int          window_fill;
    int          window_sum;
    logic        zero_held;

    reading_t    expected_readings [$];

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at result %0d: %s got %0d, want %0d",
                     readings_checked, what, got, want);
        mismatch_count++;
    endtask

    function automatic reading_t predict_reading(input logic [1:0] op,
                                                 input logic [15:0] stamp);
        logic [15:0] delta;
        int          ticks;
        logic [31:0] period;
        longint      reach;
        longint      speed;
        reading_t    r;
        r.updated = 1'b0;
        case (op)
            OP_CAPTURE: begin
                delta = stamp - last_edge;
                if (delta != 16'd0) begin
                    last_edge  = stamp;
                    period_sum = period_sum + 32'(delta);
                    edge_total = edge_total + 8'd1;
                end
            end
            OP_POLL: begin
                if (rec_enable) begin
                    delta      = stamp - last_poll;
                    last_poll  = stamp;
                    ticks      = tick_carry + int'(delta);
                    tick_carry = ticks % TICKS_PER_STEP;
                    hundredths = hundredths
                               + 16'(HUNDREDTHS_PER_STEP * (ticks / TICKS_PER_STEP));
                end
                if (edge_total >= min_edges) begin
                    period = '0;
                    // with no edges at all the period stays zero and nothing clears
                    if (edge_total != 8'd0) begin
                        period     = period_sum / 32'(edge_total);
                        period_sum = '0;
                        reach      = longint'(distance)
                                   + (MM_PER_EDGE_X10K * longint'(edge_total)) / MM_SCALE;
                        distance   = (reach > 65535) ? 16'hFFFF : 16'(reach);
                        edge_total = '0;
                    end
                    if (period == 32'd0 || period < 32'(min_ticks))
                        speed = 0;
                    else
                        speed = SPEED_NUM_X16 / (16 * longint'(period));
                    velocity  = (speed > SPEED_MAX) ? 12'hFFF : 12'(speed);
                    r.updated = 1'b1;
                    // drop the first zero after an accepted sample
                    if (velocity == 12'd0 && !zero_held) begin
                        zero_held = 1'b1;
                    end else begin
                        if (window_fill >= WINDOW_SIZE)
                            window_sum = window_sum - int'(window_mem[window_pos]);
                        else
                            window_fill++;
                        window_mem[window_pos] = velocity;
                        window_sum = (window_sum + int'(velocity)) & 'hFFFF;
                        window_pos = (window_pos + 1) % WINDOW_SIZE;
                        zero_held  = 1'b0;
                    end
                end
            end
            OP_ZERO_DIST: begin
                distance = '0;
            end
            default: begin
                hundredths = '0;
                last_poll  = '0;
            end
        endcase
        r.velocity   = velocity;
        r.average    = (window_fill == 0) ? 12'd0 : 12'(window_sum / window_fill);
        r.distance   = distance;
        r.hundredths = hundredths;
        return r;
    endfunction

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            rec_enable  = 1'b0;
            min_ticks   = MIN_TICKS_RST;
            min_edges   = MIN_EDGES_RST;
            last_edge   = '0;
            period_sum  = '0;
            edge_total  = '0;
            last_poll   = '0;
            tick_carry  = 0;
            hundredths  = '0;
            distance    = '0;
            velocity    = '0;
            window_pos  = 0;
            window_fill = 0;
            window_sum  = 0;
            zero_held   = 1'b0;
            expected_readings.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_REC_EN:    rec_enable = cfg_wdata[0];
                    CFG_MIN_TICKS: min_ticks  = cfg_wdata[15:0];
                    CFG_MIN_EDGES: min_edges  = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                want = predict_reading(s_op, s_timestamp);
                velocity_samples += int'(want.updated);
                expected_readings.push_back(want);
            end
            if (m_valid && m_ready) begin
                readings_checked++;
                if (expected_readings.size() == 0) begin
                    flag_mismatch("result with no request pending", m_distance_mm, 0);
                end else begin
                    want = expected_readings.pop_front();
                    if (m_current_velocity !== want.velocity)
                        flag_mismatch("current_velocity", m_current_velocity, want.velocity);
                    if (m_average_velocity !== want.average)
                        flag_mismatch("average_velocity", m_average_velocity, want.average);
                    if (m_distance_mm !== want.distance)
                        flag_mismatch("distance_mm", m_distance_mm, want.distance);
                    if (m_time_hundredths !== want.hundredths)
                        flag_mismatch("time_hundredths", m_time_hundredths, want.hundredths);
                    if (m_velocity_updated !== want.updated)
                        flag_mismatch("velocity_updated", m_velocity_updated, want.updated);
                end
            end
        end
        readings_pending = expected_readings.size();
    end

endmodule

// ===== test/tb_wheel_encoder_speed_odometer.sv =====
// ----------------------------------------------------------------------------
// tb_wheel_encoder_speed_odometer
// Drives encoder captures, polls and clear requests into the block in bursts,
// stalls the result side on changing patterns, and moves the registers
// between phases. A side checker predicts and compares each reading; this
// module only makes the traffic and gives the verdict.
// ----------------------------------------------------------------------------
module tb_wheel_encoder_speed_odometer;
    import wodo_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 150;
    localparam int PHASE_ITEMS  = 120;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_SQUARE
    } ready_mode_t;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_op        = OP_CAPTURE;
    logic [15:0]           s_timestamp = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [11:0]           m_current_velocity;
    logic [11:0]           m_average_velocity;
    logic [15:0]           m_distance_mm;
    logic [15:0]           m_time_hundredths;
    logic                  m_velocity_updated;

    int mismatch_count;
    int readings_pending;
    int readings_checked;
    int velocity_samples;

    // stimulus bookkeeping
    logic [15:0] edge_ts       = '0;
    logic [15:0] poll_ts       = '0;
    int          burst_left    = 0;
    int          requests_sent = 0;
    int          settings_used = 0;
    int          cur_min_ticks = MIN_TICKS_RST;
    int          cur_min_edges = MIN_EDGES_RST;

    ready_mode_t stall_mode  = READY_ALWAYS;
    int          stall_left  = 0;
    logic [7:0]  stall_tick  = '0;
    int          quiet_cycles = 0;

    wheel_encoder_speed_odometer dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_timestamp        (s_timestamp),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_current_velocity (m_current_velocity),
        .m_average_velocity (m_average_velocity),
        .m_distance_mm      (m_distance_mm),
        .m_time_hundredths  (m_time_hundredths),
        .m_velocity_updated (m_velocity_updated)
    );

    wodo_reading_checker reading_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_timestamp        (s_timestamp),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_current_velocity (m_current_velocity),
        .m_average_velocity (m_average_velocity),
        .m_distance_mm      (m_distance_mm),
        .m_time_hundredths  (m_time_hundredths),
        .m_velocity_updated (m_velocity_updated),
        .mismatch_count     (mismatch_count),
        .readings_pending   (readings_pending),
        .readings_checked   (readings_checked),
        .velocity_samples   (velocity_samples)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // result side: switch between randomly chosen stall patterns
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            stall_tick <= stall_tick + 8'd1;
            if (stall_left == 0) begin
                stall_mode <= ready_mode_t'($urandom_range(0, 3));
                stall_left <= $urandom_range(16, 400);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_COIN:   m_ready <= 1'($urandom_range(0, 1));
                READY_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
                default:      m_ready <= stall_tick[5];
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, readings_pending);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [15:0] stamp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                4, 5, 6, 7: gap = $urandom_range(1, 4);
                8:          gap = $urandom_range(5, 40);
                default:    gap = $urandom_range(41, 160);
            endcase
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_timestamp <= stamp;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        requests_sent++;
    endtask

    task automatic capture(input logic [15:0] delta);
        edge_ts = edge_ts + delta;
        send_request(OP_CAPTURE, edge_ts);
    endtask

    task automatic poll(input logic [15:0] advance);
        poll_ts = poll_ts + advance;
        send_request(OP_POLL, poll_ts);
    endtask

    // hold the sender until every outstanding reading has come back
    task automatic wait_for_results();
        s_valid    <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (readings_pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_config(input logic rec, input logic [15:0] ticks,
                              input logic [7:0] edges);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_REC_EN;
        cfg_wdata <= 16'(rec);
        @(posedge aclk);
        cfg_addr  <= CFG_MIN_TICKS;
        cfg_wdata <= ticks;
        @(posedge aclk);
        cfg_addr  <= CFG_MIN_EDGES;
        cfg_wdata <= 16'(edges);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_min_ticks = ticks;
        cur_min_edges = edges;
        settings_used++;
    endtask

    task automatic run_random_phase(input int quota);
        int issued;
        int n;
        int base;
        int d;
        logic [15:0] stamp;
        issued = 0;
        while (issued < quota) begin
            if ($urandom_range(0, 19) < 14) begin
                // one wheel stroke: a run of edges at a steady rate, then a poll
                n = $urandom_range(cur_min_edges, cur_min_edges + 3);
                case ($urandom_range(0, 3))
                    0:       base = $urandom_range(1, 40);
                    1:       base = cur_min_ticks + int'($urandom_range(0, 10)) - 5;
                    2:       base = $urandom_range(100, 3000);
                    default: base = $urandom_range(3000, 65535);
                endcase
                if (base < 1) base = 1;
                if (base > 65535) base = 65535;
                repeat (n) begin
                    d = base - base / 16 + int'($urandom_range(0, base / 8));
                    if (d < 1) d = 1;
                    if (d > 65535) d = 65535;
                    capture(16'(d));
                    issued++;
                end
                if ($urandom_range(0, 3) == 0)
                    poll(16'($urandom));
                else
                    poll(16'($urandom_range(0, 20000)));
                issued++;
            end else begin
                stamp = 16'($urandom);
                case ($urandom_range(0, 4))
                    0: capture(16'd0);
                    1: begin
                        poll(stamp);
                        issued++;
                    end
                    2: begin
                        send_request(OP_ZERO_DIST, stamp);
                        issued++;
                    end
                    3: begin
                        send_request(OP_ZERO_TIME, stamp);
                        issued++;
                    end
                    default: begin
                        edge_ts = stamp;
                        send_request(OP_CAPTURE, stamp);
                        issued++;
                    end
                endcase
            end
            if ($urandom_range(0, 59) == 0) wait_for_results();
        end
    endtask

    initial begin
        logic [15:0] ticks;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: wraps, zero delta, short period and the zero drop
        set_config(1'b1, 16'd100, 8'd2);
        poll(16'd1000);
        capture(16'd0);
        capture(16'hFFFF);
        capture(16'd1);
        poll(16'hFFFF);
        repeat (2) begin
            capture(16'd40);
            capture(16'd40);
            poll(16'd200);
        end
        send_request(OP_ZERO_DIST, 16'hFFFF);
        send_request(OP_ZERO_TIME, 16'hFFFF);
        poll(16'd300);
        // recording off, velocity overflow
        set_config(1'b0, 16'd1, 8'd1);
        capture(16'd1);
        poll(16'd500);
        capture(16'd75);
        poll(16'd500);
        // no edges required, longest period threshold
        set_config(1'b1, 16'hFFFF, 8'd0);
        poll(16'd100);
        poll(16'd100);
        capture(16'hFFFF);
        poll(16'd100);

        // long haul: full-count distance steps and a wrap of the time total
        set_config(1'b1, 16'd100, 8'd255);
        repeat (2) begin
            repeat (255) capture(16'($urandom_range(150, 400)));
            repeat (80) poll(16'hFFFF);
        end

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_config(1'b1, 16'hFFFF, 8'd1);
                1: set_config(1'b0, 16'd1, 8'd1);
                2: set_config(1'b1, MIN_TICKS_RST, MIN_EDGES_RST);
                3: set_config(1'b1, 16'd1, 8'd255);
                default: begin
                    case ($urandom_range(0, 3))
                        0:       ticks = 16'($urandom_range(1, 20));
                        1:       ticks = 16'($urandom_range(80, 400));
                        2:       ticks = 16'($urandom_range(1, 65535));
                        default: ticks = 16'hFFFF;
                    endcase
                    set_config(1'($urandom_range(0, 1)), ticks, 8'($urandom_range(1, 8)));
                end
            endcase
            run_random_phase(PHASE_ITEMS);
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d requests over %0d register settings, %0d results checked",
                 requests_sent, settings_used, readings_checked);
        $display("%0d velocity samples, with a long run of polls through the time wrap",
                 velocity_samples);
        if (readings_pending != 0)
            $display("%0d results never arrived", readings_pending);
        if (mismatch_count == 0 && readings_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
